>>> src/mlfc_pkg.sv
// ----------------------------------------------------------------------------
// mlfc_pkg: shared types and constants for the link flow control block
// Word layouts, mode and status codes, register indexes and the command
// structs that pass between the controller, the datapath and the rings.
// ----------------------------------------------------------------------------
package mlfc_pkg;

	localparam int WORD_BITS      = 16;
	localparam int RING_DEPTH_DEF = 64;
	localparam int CFG_DATA_BITS  = 7;
	localparam int LEVEL_BITS     = 7;

	localparam int VALID_POS = 13;
	localparam int BUSY_POS  = 14;

	localparam logic [WORD_BITS-1:0] WORD_ABSENT = 16'hFFFF;
	localparam logic [WORD_BITS-1:0] WORD_ESCAPE = 16'h8000;
	localparam logic [WORD_BITS-1:0] WORD_VALID  = 16'h2000;
	localparam logic [WORD_BITS-1:0] WORD_BUSY   = 16'h4000;

	localparam logic [CFG_DATA_BITS-1:0] BUSY_THRESHOLD_RESET = 7'd62;

	// Register indexes of the configuration port.
	localparam logic CFG_IS_CHILD       = 1'b0;
	localparam logic CFG_BUSY_THRESHOLD = 1'b1;

	// Item modes.
	localparam logic [1:0] MODE_EXCHANGE = 2'd0;
	localparam logic [1:0] MODE_ENQUEUE  = 2'd1;
	localparam logic [1:0] MODE_DEQUEUE  = 2'd2;
	localparam logic [1:0] MODE_RESTART  = 2'd3;

	// Sticky link status codes.
	localparam logic [1:0] LS_OK       = 2'd0;
	localparam logic [1:0] LS_EXTRA    = 2'd1;
	localparam logic [1:0] LS_ERROR    = 2'd2;
	localparam logic [1:0] LS_WRONG_ID = 2'd3;

	typedef struct packed {
		logic [1:0]           mode;
		logic [WORD_BITS-1:0] partner_word;
		logic [WORD_BITS-1:0] slot2_word;
		logic [WORD_BITS-1:0] slot3_word;
		logic                 link_error;
		logic                 link_busy;
		logic [1:0]           hw_id;
		logic [WORD_BITS-1:0] app_word;
	} item_t;

	typedef struct packed {
		logic [WORD_BITS-1:0]  send_word;
		logic                  send_write;
		logic [1:0]            link_status;
		logic [WORD_BITS-1:0]  recv_word;
		logic                  recv_valid;
		logic [LEVEL_BITS-1:0] send_level;
		logic [LEVEL_BITS-1:0] recv_level;
		logic                  recv_overflow;
		logic                  id_known;
		logic [1:0]            own_id;
	} result_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic capture;
		logic exec;
	} dp_cmd_t;

	// Datapath to ring commands.
	typedef struct packed {
		logic rd_en;
		logic push;
		logic pop;
		logic clear;
	} ring_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} ctrl_state_t;

endpackage

>>> src/mlfc_ring.sv
// ----------------------------------------------------------------------------
// mlfc_ring: word ring buffer
// A memory with head and tail pointers and a fill count. The word at the
// tail is read into a register on request, ahead of a possible pop.
// ----------------------------------------------------------------------------
module mlfc_ring #(
	parameter int DEPTH = mlfc_pkg::RING_DEPTH_DEF,
	localparam int IW = $clog2(DEPTH),
	localparam int FW = $clog2(DEPTH + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mlfc_pkg::ring_cmd_t            cmd,
	input  logic [mlfc_pkg::WORD_BITS-1:0] push_data,
	output logic [mlfc_pkg::WORD_BITS-1:0] rd_data,
	output logic [FW-1:0]                  fill,
	output logic                           full,
	output logic                           empty
);
	import mlfc_pkg::*;

	logic [WORD_BITS-1:0] mem [DEPTH];
	logic [WORD_BITS-1:0] rd_data_q;
	logic [IW-1:0]        head_q;
	logic [IW-1:0]        tail_q;
	logic [FW-1:0]        fill_q;
	logic [FW-1:0]        fill_d;

	function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] i);
		return (i == IW'(DEPTH - 1)) ? '0 : i + IW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[head_q] <= push_data;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem[tail_q];
		end
	end

	always_comb begin
		if (cmd.clear) begin
			fill_d = '0;
		end else if (cmd.push && !cmd.pop) begin
			fill_d = fill_q + FW'(1);
		end else if (cmd.pop && !cmd.push) begin
			fill_d = fill_q - FW'(1);
		end else begin
			fill_d = fill_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
		end else begin
			fill_q <= fill_d;
			if (cmd.clear) begin
				head_q <= '0;
				tail_q <= '0;
			end else begin
				if (cmd.push) begin
					head_q <= next_idx(head_q);
				end
				if (cmd.pop) begin
					tail_q <= next_idx(tail_q);
				end
			end
		end
	end

	assign rd_data = rd_data_q;
	assign fill    = fill_q;
	assign full    = (fill_q == FW'(DEPTH));
	assign empty   = (fill_q == '0);

endmodule

>>> src/mlfc_ctrl.sv
// ----------------------------------------------------------------------------
// mlfc_ctrl: handshake controller
// Takes a word when idle, lets the datapath read the rings, then executes
// the step once the result register is free.
// ----------------------------------------------------------------------------
module mlfc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	output logic              result_valid,
	input  logic              result_stall,
	output mlfc_pkg::dp_cmd_t cmd
);
	import mlfc_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        result_valid_q;
	logic        out_free;

	assign item_stall = (state_q != ST_IDLE);
	assign out_free   = !result_valid_q || !result_stall;

	always_comb begin
		state_d     = state_q;
		cmd.capture = 1'b0;
		cmd.exec    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (out_free) begin
					cmd.exec = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = result_valid_q;

endmodule

>>> src/mlfc_datapath.sv
// ----------------------------------------------------------------------------
// mlfc_datapath: link step datapath
// Holds the captured word, the configuration and sticky status registers,
// both rings and the result register, and works out one step on command.
// ----------------------------------------------------------------------------
module mlfc_datapath #(
	parameter int RING_DEPTH = mlfc_pkg::RING_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  mlfc_pkg::dp_cmd_t                  cmd,
	input  mlfc_pkg::item_t                    item,
	output mlfc_pkg::result_t                  result,
	input  logic                               cfg_write,
	input  logic                               cfg_index,
	input  logic [mlfc_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import mlfc_pkg::*;

	localparam int FW = $clog2(RING_DEPTH + 1);
	localparam int CW = (FW > CFG_DATA_BITS) ? FW : CFG_DATA_BITS;

	item_t   item_q;
	result_t res_q;
	result_t res_d;

	logic                     is_child_q;
	logic [CFG_DATA_BITS-1:0] busy_threshold_q;
	logic [1:0]               status_q, status_d;
	logic                     ovf_q, ovf_d;
	logic                     known_q, known_d;
	logic [1:0]               id_q, id_d;

	ring_cmd_t            rcmd, scmd;
	logic [WORD_BITS-1:0] r_rd, s_rd;
	logic [FW-1:0]        r_fill, s_fill;
	logic                 r_full, r_empty, s_full, s_empty;

	logic                 extra, fault_err, store, push_ok, own_busy;
	logic [CW-1:0]        r_after_c;
	logic [FW-1:0]        r_after, s_after;
	logic [WORD_BITS-1:0] send_v;

	mlfc_ring #(.DEPTH(RING_DEPTH)) u_recv_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (rcmd),
		.push_data (item_q.partner_word),
		.rd_data   (r_rd),
		.fill      (r_fill),
		.full      (r_full),
		.empty     (r_empty)
	);

	mlfc_ring #(.DEPTH(RING_DEPTH)) u_send_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (scmd),
		.push_data (item_q.app_word),
		.rd_data   (s_rd),
		.fill      (s_fill),
		.full      (s_full),
		.empty     (s_empty)
	);

	assign extra = (item_q.slot2_word != WORD_ABSENT) || (item_q.slot3_word != WORD_ABSENT);
	// A parent also treats a transfer that is still busy as an error.
	assign fault_err = item_q.link_error || (!is_child_q && item_q.link_busy);
	// An all-ones partner word has the valid bit set but means nothing.
	assign store = item_q.partner_word[VALID_POS] && (item_q.partner_word != WORD_ABSENT);
	assign push_ok = store && !r_full;
	assign r_after_c = CW'(r_fill) + CW'(push_ok);
	assign own_busy = (r_after_c > CW'(busy_threshold_q));

	always_comb begin
		rcmd       = '0;
		scmd       = '0;
		rcmd.rd_en = cmd.capture;
		scmd.rd_en = cmd.capture;
		res_d      = '0;
		status_d   = status_q;
		ovf_d      = ovf_q;
		known_d    = known_q;
		id_d       = id_q;
		send_v     = '0;
		if (cmd.exec) begin
			case (item_q.mode)
				MODE_EXCHANGE: begin
					if (extra || fault_err) begin
						status_d = extra ? LS_EXTRA : LS_ERROR;
					end else begin
						if (store) begin
							if (r_full) begin
								ovf_d = 1'b1;
							end else begin
								rcmd.push = 1'b1;
							end
						end
						if (own_busy) begin
							send_v = WORD_BUSY;
						end
						if (!s_empty && !item_q.partner_word[BUSY_POS]) begin
							send_v    = send_v | s_rd | WORD_VALID;
							scmd.pop  = 1'b1;
						end
						if (send_v == WORD_ABSENT) begin
							send_v = WORD_ESCAPE;
						end
						res_d.send_word  = send_v;
						res_d.send_write = 1'b1;
						if (is_child_q && !known_q) begin
							known_d = 1'b1;
							id_d    = item_q.hw_id;
							if (item_q.hw_id != 2'd1) begin
								status_d = LS_WRONG_ID;
							end
						end
					end
				end
				MODE_ENQUEUE: begin
					if (!s_full) begin
						scmd.push = 1'b1;
					end
				end
				MODE_DEQUEUE: begin
					if (!r_empty) begin
						rcmd.pop         = 1'b1;
						res_d.recv_word  = r_rd;
						res_d.recv_valid = 1'b1;
					end
				end
				default: begin
					rcmd.clear = 1'b1;
					scmd.clear = 1'b1;
					status_d   = LS_OK;
					ovf_d      = 1'b0;
					known_d    = !is_child_q;
					id_d       = 2'd0;
				end
			endcase
		end
		r_after = rcmd.clear ? '0 : r_fill + FW'(rcmd.push) - FW'(rcmd.pop);
		s_after = scmd.clear ? '0 : s_fill + FW'(scmd.push) - FW'(scmd.pop);
		res_d.send_level    = LEVEL_BITS'(s_after);
		res_d.recv_level    = LEVEL_BITS'(r_after);
		res_d.link_status   = status_d;
		res_d.recv_overflow = ovf_d;
		res_d.id_known      = known_d;
		res_d.own_id        = known_d ? id_d : 2'd0;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
		end
		if (cmd.exec) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_child_q       <= 1'b0;
			busy_threshold_q <= BUSY_THRESHOLD_RESET;
			status_q         <= LS_OK;
			ovf_q            <= 1'b0;
			known_q          <= 1'b0;
			id_q             <= 2'd0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_IS_CHILD: begin
						is_child_q <= cfg_data[0];
					end
					CFG_BUSY_THRESHOLD: begin
						busy_threshold_q <= cfg_data;
					end
					default: begin
						is_child_q <= is_child_q;
					end
				endcase
			end
			status_q <= status_d;
			ovf_q    <= ovf_d;
			known_q  <= known_d;
			id_q     <= id_d;
		end
	end

	assign result = res_q;

endmodule

>>> src/multiplayer_link_flow_control.sv
// ----------------------------------------------------------------------------
// multiplayer_link_flow_control: link-layer step with receive and send rings
// An accepted word is captured and the ring memories' registered read is
// started in the idle state; the state update follows in the exec state,
// which waits while a held result is stalled. No new word is taken before it.
// Reset clears pointers, fill counts, status, overflow and the id; ring
// contents stay undefined and are only read where written.
// ----------------------------------------------------------------------------
module multiplayer_link_flow_control #(
	parameter int RING_DEPTH = mlfc_pkg::RING_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_stall,
	input  mlfc_pkg::item_t                    item,
	output logic                               result_valid,
	input  logic                               result_stall,
	output mlfc_pkg::result_t                  result,
	input  logic                               cfg_write,
	input  logic                               cfg_index,
	input  logic [mlfc_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import mlfc_pkg::*;

	dp_cmd_t cmd;

	mlfc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd)
	);

	mlfc_datapath #(.RING_DEPTH(RING_DEPTH)) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.item      (item),
		.result    (result),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule
